// File: rtl/mbec_pkg.sv
// Shared constants, command codes and control types for the Markov burst-error channel.
// No dependencies; all files but mbec_ram take names from here by scope.
package mbec_pkg;

    localparam int NUM_STATES = 10;
    localparam int HIST_BINS  = 1024;

    localparam int CMD_W   = 3;
    localparam int STATE_W = 4;
    localparam int PROB_W  = 17;
    localparam int DRAW_W  = 16;
    localparam int CNT_W   = 10;
    localparam int BIN_W   = 32;

    localparam int ROW_AW  = $clog2(NUM_STATES);
    localparam int HIST_AW = $clog2(HIST_BINS);

    localparam logic [CMD_W-1:0] CMD_SYMBOL    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WR_TRANS  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WR_ERR    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RD_BIN    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET_STATE = 3'd4;

    localparam logic [STATE_W:0] STATE_LIMIT = (STATE_W + 1)'(NUM_STATES);
    localparam logic [CNT_W-1:0] TALLY_MAX   = '1;
    localparam logic [CNT_W-1:0] LEN_RESET   = 10'd16;

    typedef struct packed {
        logic               rd_en;
        logic [HIST_AW-1:0] rd_addr;
        logic               wr_en;
    } hist_ctl_t;

endpackage

// File: rtl/mbec_item_if.sv
// Input channel of the burst-error channel: valid/ready handshake and one command beat.
// Depends on mbec_pkg for field widths.
interface mbec_item_if;
    logic                          valid;
    logic                          ready;
    logic [mbec_pkg::CMD_W-1:0]    command;
    logic [mbec_pkg::STATE_W-1:0]  from_state;
    logic [mbec_pkg::STATE_W-1:0]  to_state;
    logic [mbec_pkg::PROB_W-1:0]   probability;
    logic [mbec_pkg::DRAW_W-1:0]   move_draw;
    logic [mbec_pkg::DRAW_W-1:0]   error_draw;
    logic [mbec_pkg::CNT_W-1:0]    bin_index;

    modport source (
        output valid, command, from_state, to_state, probability, move_draw, error_draw,
               bin_index,
        input  ready
    );
    modport sink (
        input  valid, command, from_state, to_state, probability, move_draw, error_draw,
               bin_index,
        output ready
    );
endinterface

// File: rtl/mbec_result_if.sv
// Result channel of the burst-error channel: valid/ready handshake and one result beat.
// Depends on mbec_pkg for field widths.
interface mbec_result_if;
    logic                          valid;
    logic                          ready;
    logic [mbec_pkg::STATE_W-1:0]  current_state;
    logic                          symbol_error;
    logic [mbec_pkg::CNT_W-1:0]    errors_in_message;
    logic                          message_end;
    logic [mbec_pkg::BIN_W-1:0]    bin_count;

    modport source (
        output valid, current_state, symbol_error, errors_in_message, message_end, bin_count,
        input  ready
    );
    modport sink (
        input  valid, current_state, symbol_error, errors_in_message, message_end, bin_count,
        output ready
    );
endinterface

// File: rtl/mbec_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module mbec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/mbec_hist.sv
// Error-count histogram: RAM with clearing pass after reset, saturating read-modify-write
// and forwarding of the last write. Depends on mbec_pkg and mbec_ram.
module mbec_hist (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mbec_pkg::hist_ctl_t           ctl,
    output logic [mbec_pkg::BIN_W-1:0]    count,
    output logic                          clearing
);

    logic                             clear_reg;
    logic                             clear_next;
    logic [mbec_pkg::HIST_AW-1:0]     clr_cnt_reg;
    logic [mbec_pkg::HIST_AW-1:0]     clr_cnt_next;
    logic [mbec_pkg::HIST_AW-1:0]     pend_addr_reg;
    logic                             lw_valid_reg;
    logic [mbec_pkg::HIST_AW-1:0]     lw_addr_reg;
    logic [mbec_pkg::BIN_W-1:0]       lw_data_reg;
    logic [mbec_pkg::BIN_W-1:0]       ram_rd_data;
    logic [mbec_pkg::BIN_W-1:0]       cur_count;
    logic                             ram_wr_en;
    logic [mbec_pkg::HIST_AW-1:0]     ram_wr_addr;
    logic [mbec_pkg::BIN_W-1:0]       ram_wr_data;

    // Last write wins over stale read data from the same edge
    always_comb
    begin
        if (lw_valid_reg && (lw_addr_reg == pend_addr_reg))
        begin
            cur_count = lw_data_reg;
        end
        else
        begin
            cur_count = ram_rd_data;
        end
    end

    always_comb
    begin
        clear_next   = clear_reg;
        clr_cnt_next = clr_cnt_reg;
        if (clear_reg)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_reg;
            ram_wr_data = '0;
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == mbec_pkg::HIST_AW'(mbec_pkg::HIST_BINS - 1))
            begin
                clear_next = 1'b0;
            end
        end
        else
        begin
            ram_wr_en   = ctl.wr_en;
            ram_wr_addr = pend_addr_reg;
            // Hold a full bin at all ones
            ram_wr_data = (cur_count == '1) ? cur_count : cur_count + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg    <= 1'b1;
            clr_cnt_reg  <= '0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            clear_reg   <= clear_next;
            clr_cnt_reg <= clr_cnt_next;
            if (ram_wr_en)
            begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_wr_en)
        begin
            lw_addr_reg <= ram_wr_addr;
            lw_data_reg <= ram_wr_data;
        end
        if (ctl.rd_en)
        begin
            pend_addr_reg <= ctl.rd_addr;
        end
    end

    mbec_ram #(
        .WIDTH (mbec_pkg::BIN_W),
        .DEPTH (mbec_pkg::HIST_BINS)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ctl.rd_en),
        .rd_addr (ctl.rd_addr),
        .rd_data (ram_rd_data)
    );

    assign count    = cur_count;
    assign clearing = clear_reg;

    a_no_update_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_en |-> !clear_reg)
        else $error("histogram update during clearing pass");

    a_clear_covers_all_bins: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clear_reg) |-> $past(clr_cnt_reg) == mbec_pkg::HIST_AW'(mbec_pkg::HIST_BINS - 1))
        else $error("clearing pass ended early");

endmodule

// File: rtl/markov_burst_error_channel.sv
// Markov-chain burst-error channel: per-row transition RAMs, error table, state, histogram.
// Depends on mbec_pkg, mbec_item_if, mbec_result_if, mbec_ram and mbec_hist.
//
// Usage: each beat on item carries one command (symbol step, transition or error
// probability write, histogram bin read, set state); each accepted beat gives exactly one
// beat on result. cfg_we/cfg_data set the message length; write it only while idle.
// Pipeline: an item passes three registers (transition RAM read, state update, histogram
// read-modify-write) before result.valid rises; the result then waits in the output
// register.
// Throughput: one item per cycle while result.ready is high. The rate is set by the state
// loop in the update stage: row select, draw compare, error-table lookup, tally update.
// Histogram increments of back-to-back messages on the same bin are forwarded.
// Reset: state, position, tally and error table clear at once; the histogram and the
// transition rows are then swept to zero in a pass over all HIST_BINS bins (1024), during
// which item.ready is low.
// Stalls: when result.ready is low the result holds; the two internal stages keep
// filling, so up to two more items are taken before item.ready drops.
module markov_burst_error_channel (
    input  logic                        clk,
    input  logic                        rst_n,
    mbec_item_if.sink                   item,
    mbec_result_if.source               result,
    input  logic                        cfg_we,
    input  logic [mbec_pkg::CNT_W-1:0]  cfg_data
);

    localparam int NS = mbec_pkg::NUM_STATES;

    // Flow control
    logic out_go, s2_go, s2_free, s1_go, s1_free, accept, clearing;

    // Configuration and channel state
    logic [mbec_pkg::CNT_W-1:0]   len_reg;
    logic [mbec_pkg::STATE_W-1:0] state_reg, state_next;
    logic [mbec_pkg::CNT_W-1:0]   pos_reg, pos_next;
    logic [mbec_pkg::CNT_W-1:0]   tally_reg, tally_next;
    logic [mbec_pkg::PROB_W-1:0]  err_reg [NS];
    logic [mbec_pkg::ROW_AW-1:0]  row_clr_reg;

    // Stage 1 payload
    logic                          s1_valid_reg;
    logic [mbec_pkg::CMD_W-1:0]    s1_cmd_reg;
    logic [mbec_pkg::STATE_W-1:0]  s1_from_reg;
    logic [mbec_pkg::STATE_W-1:0]  s1_to_reg;
    logic [mbec_pkg::DRAW_W-1:0]   s1_mdraw_reg;
    logic [mbec_pkg::DRAW_W-1:0]   s1_edraw_reg;
    logic [mbec_pkg::CNT_W-1:0]    s1_bin_reg;
    logic [mbec_pkg::PROB_W-1:0]   trans_rd [NS];

    // Stage 1 logic
    logic                          s1_sym, s1_moved, s1_err, s1_end, s1_read_ok;
    logic [mbec_pkg::PROB_W-1:0]   row_prob;
    logic [mbec_pkg::STATE_W-1:0]  state_sym;
    logic [mbec_pkg::CNT_W-1:0]    tally_inc, len_eff;
    logic [mbec_pkg::HIST_AW-1:0]  end_bin;
    mbec_pkg::hist_ctl_t           hist_ctl;
    logic [mbec_pkg::BIN_W-1:0]    hist_count;

    // Stage 2 and output
    logic                          s2_valid_reg, s2_err_reg, s2_end_reg, s2_read_reg;
    logic [mbec_pkg::STATE_W-1:0]  s2_state_reg;
    logic [mbec_pkg::CNT_W-1:0]    s2_tally_reg;
    logic                          out_valid_reg, out_err_reg, out_end_reg;
    logic [mbec_pkg::STATE_W-1:0]  out_state_reg;
    logic [mbec_pkg::CNT_W-1:0]    out_tally_reg;
    logic [mbec_pkg::BIN_W-1:0]    out_count_reg;

    logic item_from_ok, item_to_ok;

    assign out_go  = !out_valid_reg || result.ready;
    assign s2_go   = s2_valid_reg && out_go;
    assign s2_free = !s2_valid_reg || out_go;
    assign s1_go   = s1_valid_reg && s2_free;
    assign s1_free = !s1_valid_reg || s1_go;
    assign item.ready = s1_free && !clearing;
    assign accept  = item.valid && item.ready;

    assign item_from_ok = {1'b0, item.from_state} < mbec_pkg::STATE_LIMIT;
    assign item_to_ok   = {1'b0, item.to_state} < mbec_pkg::STATE_LIMIT;

    // Transition table: one RAM per row, addressed by column, so the row is chosen after
    // the read from the registered state
    for (genvar r = 0; r < NS; r++)
    begin : g_row
        logic row_we;
        assign row_we = accept && (item.command == mbec_pkg::CMD_WR_TRANS) &&
                        item_from_ok && item_to_ok &&
                        (item.from_state == mbec_pkg::STATE_W'(r));
        mbec_ram #(
            .WIDTH (mbec_pkg::PROB_W),
            .DEPTH (NS)
        ) u_row_ram (
            .clk     (clk),
            .wr_en   (row_we || clearing),
            .wr_addr (clearing ? row_clr_reg : item.to_state[mbec_pkg::ROW_AW-1:0]),
            .wr_data (clearing ? mbec_pkg::PROB_W'(0) : item.probability),
            .rd_en   (accept),
            .rd_addr (item.to_state[mbec_pkg::ROW_AW-1:0]),
            .rd_data (trans_rd[r])
        );
    end

    // Sweep the transition columns to zero while the histogram clears
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_clr_reg <= '0;
        end
        else if (clearing)
        begin
            if (row_clr_reg == mbec_pkg::ROW_AW'(NS - 1))
            begin
                row_clr_reg <= '0;
            end
            else
            begin
                row_clr_reg <= row_clr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                err_reg[i] <= '0;
            end
        end
        else if (accept && (item.command == mbec_pkg::CMD_WR_ERR) && item_from_ok)
        begin
            err_reg[item.from_state[mbec_pkg::ROW_AW-1:0]] <= item.probability;
        end
    end

    // State update
    always_comb
    begin
        s1_sym    = (s1_cmd_reg == mbec_pkg::CMD_SYMBOL);
        row_prob  = trans_rd[state_reg[mbec_pkg::ROW_AW-1:0]];
        s1_moved  = s1_sym && ({1'b0, s1_to_reg} < mbec_pkg::STATE_LIMIT) &&
                    ({1'b0, s1_mdraw_reg} <= row_prob);
        state_sym = s1_moved ? s1_to_reg : state_reg;
        s1_err    = s1_sym &&
                    ({1'b0, s1_edraw_reg} <= err_reg[state_sym[mbec_pkg::ROW_AW-1:0]]);
        tally_inc = (s1_err && (tally_reg != mbec_pkg::TALLY_MAX)) ? tally_reg + 1'b1
                                                                   : tally_reg;
        len_eff   = (len_reg == '0) ? mbec_pkg::CNT_W'(1) : len_reg;
        s1_end    = s1_sym && (({1'b0, pos_reg} + 1'b1) >= {1'b0, len_eff});

        if ((s1_cmd_reg == mbec_pkg::CMD_SET_STATE) &&
            ({1'b0, s1_from_reg} < mbec_pkg::STATE_LIMIT))
        begin
            state_next = s1_from_reg;
        end
        else
        begin
            state_next = state_sym;
        end

        if (s1_end)
        begin
            pos_next   = '0;
            tally_next = '0;
        end
        else
        begin
            pos_next   = s1_sym ? pos_reg + 1'b1 : pos_reg;
            tally_next = tally_inc;
        end

        // Counts beyond the histogram land in the last bin
        if (32'(tally_inc) < 32'(mbec_pkg::HIST_BINS))
        begin
            end_bin = mbec_pkg::HIST_AW'(tally_inc);
        end
        else
        begin
            end_bin = mbec_pkg::HIST_AW'(mbec_pkg::HIST_BINS - 1);
        end

        s1_read_ok = (s1_cmd_reg == mbec_pkg::CMD_RD_BIN) &&
                     (32'(s1_bin_reg) < 32'(mbec_pkg::HIST_BINS));

        hist_ctl.rd_en   = s1_go && (s1_end || s1_read_ok);
        hist_ctl.rd_addr = s1_end ? end_bin : mbec_pkg::HIST_AW'(s1_bin_reg);
        hist_ctl.wr_en   = s2_go && s2_end_reg;
    end

    mbec_hist u_hist (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (hist_ctl),
        .count    (hist_count),
        .clearing (clearing)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= mbec_pkg::LEN_RESET;
            state_reg     <= '0;
            pos_reg       <= '0;
            tally_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg <= cfg_data;
            end
            if (s1_go)
            begin
                state_reg <= state_next;
                pos_reg   <= pos_next;
                tally_reg <= tally_next;
            end
            if (s1_free)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_go;
            end
            if (out_go)
            begin
                out_valid_reg <= s2_go;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg   <= item.command;
            s1_from_reg  <= item.from_state;
            s1_to_reg    <= item.to_state;
            s1_mdraw_reg <= item.move_draw;
            s1_edraw_reg <= item.error_draw;
            s1_bin_reg   <= item.bin_index;
        end
        if (s1_go)
        begin
            s2_state_reg <= state_next;
            s2_err_reg   <= s1_err;
            s2_tally_reg <= tally_inc;
            s2_end_reg   <= s1_end;
            s2_read_reg  <= s1_read_ok;
        end
        if (s2_go)
        begin
            out_state_reg <= s2_state_reg;
            out_err_reg   <= s2_err_reg;
            out_tally_reg <= s2_tally_reg;
            out_end_reg   <= s2_end_reg;
            out_count_reg <= s2_read_reg ? hist_count : '0;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.current_state     = out_state_reg;
    assign result.symbol_error      = out_err_reg;
    assign result.errors_in_message = out_tally_reg;
    assign result.message_end       = out_end_reg;
    assign result.bin_count         = out_count_reg;

    a_end_restarts_message: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && s1_end |=> (pos_reg == '0) && (tally_reg == '0))
        else $error("message end did not restart position and tally");

    a_tally_within_position: assert property (@(posedge clk) disable iff (!rst_n)
        tally_reg <= pos_reg)
        else $error("error tally exceeds symbols seen in message");

    a_bad_candidate_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && s1_sym && ({1'b0, s1_to_reg} >= mbec_pkg::STATE_LIMIT)
        |=> state_reg == $past(state_reg))
        else $error("state moved to an out-of-range candidate");

endmodule
